/* hdl/competitive_learning_foreground_detect_core_defines.svh */
// ----------------------------------------------------------------------------
// Foreground detector assertion macros
// Shared property forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef COMPETITIVE_LEARNING_FOREGROUND_DETECT_CORE_DEFINES_SVH
`define COMPETITIVE_LEARNING_FOREGROUND_DETECT_CORE_DEFINES_SVH

// same-cycle implication
`define CLFD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLFD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/clfd_pkg.sv */
// ----------------------------------------------------------------------------
// Foreground detector package
// Shared constants, register indexes, FSM states and control structs.
// ----------------------------------------------------------------------------
package clfd_pkg;

    localparam int PIXELS_DEF   = 65536;
    localparam int NEURONS_DEF  = 4;
    localparam int CHANNELS_DEF = 3;
    localparam int MAX_CH       = 3;

    localparam logic [16:0] RATE_ONE = 17'h10000;

    typedef enum logic {
        CMD_CLASSIFY = 1'b0,
        CMD_INIT     = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        REG_THRESH   = 3'd0,
        REG_COEF_WIN = 3'd1,
        REG_COEF_ALL = 3'd2,
        REG_REINIT_EN  = 3'd3,
        REG_REINIT_LIM = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_LOAD,
        ST_SQ,
        ST_ACC,
        ST_MUL,
        ST_BLEND,
        ST_WB,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr;
        logic accept;
        logic mod;
        logic rd;
        logic load;
        logic sq;
        logic acc;
        logic mul;
        logic blend;
        logic wb;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic clr_done;
        logic is_init;
        logic n_last;
        logic out_busy;
    } sts_t;

endpackage

/* hdl/clfd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/clfd_ctrl.sv */
// ----------------------------------------------------------------------------
// Foreground detector controller
// Sequences clearing, index reduction, read, distance, update and writeback.
// ----------------------------------------------------------------------------
module clfd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  clfd_pkg::sts_t  sts,
    output clfd_pkg::ctl_t  ctl
);

    clfd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clfd_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            clfd_pkg::ST_CLEAR:  if (sts.clr_done) state_next = clfd_pkg::ST_IDLE;
            clfd_pkg::ST_IDLE:   if (s_tvalid) state_next = clfd_pkg::ST_MOD;
            clfd_pkg::ST_MOD:    state_next = clfd_pkg::ST_READ;
            clfd_pkg::ST_READ:   state_next = clfd_pkg::ST_LOAD;
            clfd_pkg::ST_LOAD:   state_next = sts.is_init ? clfd_pkg::ST_WB : clfd_pkg::ST_SQ;
            clfd_pkg::ST_SQ:     state_next = clfd_pkg::ST_ACC;
            clfd_pkg::ST_ACC:    state_next = sts.n_last ? clfd_pkg::ST_MUL : clfd_pkg::ST_SQ;
            clfd_pkg::ST_MUL:    state_next = clfd_pkg::ST_BLEND;
            clfd_pkg::ST_BLEND:  state_next = sts.n_last ? clfd_pkg::ST_WB : clfd_pkg::ST_MUL;
            clfd_pkg::ST_WB:     state_next = clfd_pkg::ST_FINISH;
            clfd_pkg::ST_FINISH: if (!sts.out_busy) state_next = clfd_pkg::ST_IDLE;
            default:             state_next = clfd_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == clfd_pkg::ST_IDLE);
        ctl        = '0;
        ctl.clr    = (state_reg == clfd_pkg::ST_CLEAR);
        ctl.accept = s_tready && s_tvalid;
        ctl.mod    = (state_reg == clfd_pkg::ST_MOD);
        ctl.rd     = (state_reg == clfd_pkg::ST_READ);
        ctl.load   = (state_reg == clfd_pkg::ST_LOAD);
        ctl.sq     = (state_reg == clfd_pkg::ST_SQ);
        ctl.acc    = (state_reg == clfd_pkg::ST_ACC);
        ctl.mul    = (state_reg == clfd_pkg::ST_MUL);
        ctl.blend  = (state_reg == clfd_pkg::ST_BLEND);
        ctl.wb     = (state_reg == clfd_pkg::ST_WB);
        ctl.finish = (state_reg == clfd_pkg::ST_FINISH) && !sts.out_busy;
    end

endmodule

/* hdl/clfd_dp.sv */
// ----------------------------------------------------------------------------
// Foreground detector datapath
// Pixel model memories, distance/min search, prototype blend, result register.
// ----------------------------------------------------------------------------
module clfd_dp #(
    parameter int PIXELS   = clfd_pkg::PIXELS_DEF,
    parameter int NEURONS  = clfd_pkg::NEURONS_DEF,
    parameter int CHANNELS = clfd_pkg::CHANNELS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  clfd_pkg::ctl_t ctl,
    output clfd_pkg::sts_t sts,
    input  logic [33:0]    thresh,
    input  logic [16:0]    coef_win,
    input  logic [16:0]    coef_all,
    input  logic           reinit_en,
    input  logic [15:0]    reinit_lim,
    input  logic [39:0]    s_tdata,   // pixel_index, channel_a, channel_b, channel_c
    input  logic           s_tuser,   // command
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [55:0]    m_tdata,   // min_distance, winner, fg_count, pad
    output logic           m_tuser    // is_background
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int PW = NEURONS * CHANNELS * 16;
    localparam logic [24:0] RECIP = 25'((64'd1 << 24) / PIXELS);
    localparam logic [21:0] PIX_C = 22'(PIXELS);

    // input item
    logic              cmd_reg;
    logic [15:0]       idx_reg;
    logic [7:0]        smp_reg [clfd_pkg::MAX_CH];
    // index reduction
    logic [16:0]       q_reg;
    logic [AW-1:0]     addr, addr_reg;
    logic [37:0]       qp;
    logic [21:0]       rem;
    // memories
    logic [PW-1:0]     proto_rd;
    logic [15:0]       cnt_rd;
    logic [AW-1:0]     clr_addr_reg;
    logic              cnt_we;
    logic [AW-1:0]     cnt_waddr;
    // working state
    logic [PW-1:0]     proto_reg, proto_next, init_word;
    logic [15:0]       cnt_reg, cnt_new;
    logic [NW-1:0]     n_reg;
    logic              n_last;
    logic [31:0]       sq_reg [clfd_pkg::MAX_CH], sq_next [clfd_pkg::MAX_CH];
    logic [33:0]       sum;
    logic [33:0]       best_reg;
    logic [3:0]        win_reg;
    logic [32:0]       pa_reg [clfd_pkg::MAX_CH], pa_next [clfd_pkg::MAX_CH];
    logic [24:0]       pb_reg [clfd_pkg::MAX_CH], pb_next [clfd_pkg::MAX_CH];
    logic [16:0]       rate_a, rate_w, rate;
    logic [17:0]       rate_sum;
    logic              bg, bg_reg, reinit;
    // output
    logic              m_tvalid_reg;
    logic [55:0]       m_tdata_reg;
    logic              m_tuser_reg;

    // index modulo PIXELS: reciprocal estimate, then one correction
    always_comb begin
        qp   = 38'(q_reg) * 38'(PIX_C);
        rem  = 22'(38'(idx_reg) - qp);
        if (rem >= PIX_C) begin
            rem = rem - PIX_C;
        end
        addr = AW'(rem);
    end

    assign n_last = (n_reg == NW'(NEURONS - 1));

    assign cnt_we    = ctl.clr || ctl.wb;
    assign cnt_waddr = ctl.clr ? clr_addr_reg : addr_reg;

    clfd_ram #(.WIDTH(PW), .DEPTH(PIXELS), .AW(AW)) u_proto_ram (
        .aclk  (aclk),
        .we    (ctl.wb),
        .waddr (addr_reg),
        .wdata (proto_reg),
        .re    (ctl.rd),
        .raddr (addr),
        .rdata (proto_rd)
    );

    clfd_ram #(.WIDTH(16), .DEPTH(PIXELS), .AW(AW)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (ctl.clr ? 16'd0 : cnt_new),
        .re    (ctl.rd),
        .raddr (addr),
        .rdata (cnt_rd)
    );

    always_comb begin
        for (int n = 0; n < NEURONS; n++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                init_word[(n*CHANNELS + c)*16 +: 16] = {smp_reg[c], 8'h00};
            end
        end
    end

    assign reinit = (cmd_reg == clfd_pkg::CMD_INIT) || (reinit_en && (cnt_rd > reinit_lim));

    assign rate_a   = (coef_all > clfd_pkg::RATE_ONE) ? clfd_pkg::RATE_ONE : coef_all;
    assign rate_sum = 18'(coef_all) + 18'(coef_win);
    assign rate_w   = (rate_sum > 18'(clfd_pkg::RATE_ONE)) ? clfd_pkg::RATE_ONE
                                                           : rate_sum[16:0];
    assign rate     = (4'(n_reg) == win_reg) ? rate_w : rate_a;

    // per-channel lanes for the current neuron
    always_comb begin
        logic [15:0]        p;
        logic signed [16:0] d;
        logic signed [33:0] dx;
        logic [33:0]        acc;
        proto_next = proto_reg;
        sum        = '0;
        for (int c = 0; c < clfd_pkg::MAX_CH; c++) begin
            sq_next[c] = '0;
            pa_next[c] = '0;
            pb_next[c] = '0;
            if (c < CHANNELS) begin
                p  = proto_reg[(int'(n_reg)*CHANNELS + c)*16 +: 16];
                d  = $signed({1'b0, smp_reg[c], 8'h00}) - $signed({1'b0, p});
                dx = 34'(d);
                sq_next[c] = 32'(dx * dx);
                pa_next[c] = 33'(p) * 33'(clfd_pkg::RATE_ONE - rate);
                pb_next[c] = 25'(smp_reg[c]) * 25'(rate);
                acc = 34'(pa_reg[c]) + {1'b0, pb_reg[c], 8'h00} + 34'd32768;
                proto_next[(int'(n_reg)*CHANNELS + c)*16 +: 16] = acc[31:16];
            end
            sum = sum + 34'(sq_reg[c]);
        end
    end

    assign bg = (cmd_reg == clfd_pkg::CMD_INIT) || (best_reg < thresh);

    always_comb begin
        if (bg) begin
            cnt_new = 16'd0;
        end else if (cnt_reg == 16'hFFFF) begin
            cnt_new = cnt_reg;
        end else begin
            cnt_new = cnt_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            cmd_reg    <= s_tuser;
            idx_reg    <= s_tdata[15:0];
            smp_reg[0] <= s_tdata[23:16];
            smp_reg[1] <= s_tdata[31:24];
            smp_reg[2] <= s_tdata[39:32];
        end
        if (ctl.mod) begin
            q_reg <= 17'((41'(idx_reg) * 41'(RECIP)) >> 24);
        end
        if (ctl.rd) begin
            addr_reg <= addr;
        end
        if (ctl.load) begin
            proto_reg <= reinit ? init_word : proto_rd;
            cnt_reg   <= reinit ? 16'd0 : cnt_rd;
            best_reg  <= '0;
            win_reg   <= '0;
            n_reg     <= '0;
        end
        if (ctl.sq) begin
            sq_reg <= sq_next;
        end
        if (ctl.acc) begin
            if (n_reg == '0 || sum < best_reg) begin
                best_reg <= sum;
                win_reg  <= 4'(n_reg);
            end
        end
        if (ctl.mul) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (ctl.blend) begin
            proto_reg <= proto_next;
        end
        if (ctl.acc || ctl.blend) begin
            n_reg <= n_last ? '0 : n_reg + NW'(1);
        end
        if (ctl.wb) begin
            cnt_reg <= cnt_new;
            bg_reg  <= bg;
        end
        if (ctl.finish) begin
            m_tdata_reg <= {2'b00, cnt_reg, win_reg, best_reg};
            m_tuser_reg <= bg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ctl.clr) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (ctl.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        sts          = '0;
        sts.clr_done = (clr_addr_reg == AW'(PIXELS - 1));
        sts.is_init  = (cmd_reg == clfd_pkg::CMD_INIT);
        sts.n_last   = n_last;
        sts.out_busy = m_tvalid_reg && !m_tready;
    end

endmodule

/* hdl/competitive_learning_foreground_detect_core.sv */
// Items: one is in work at a time, from accept until the result is valid; s_tready stays
//   low meanwhile. Classify makes a distance pass and a blend pass per neuron; initialise
//   makes neither. Pace is set by these passes through one set of channel lanes.
// Reset: synchronous active-low; afterwards the run counter memory is cleared over all
//   PIXELS addresses (s_tready low, configuration writes still taken).
// ----------------------------------------------------------------------------
// Competitive-learning foreground detector
// Top level: APB register file, controller and datapath.
// ----------------------------------------------------------------------------
module competitive_learning_foreground_detect_core #(
    parameter int PIXELS   = clfd_pkg::PIXELS_DEF,
    parameter int NEURONS  = clfd_pkg::NEURONS_DEF,
    parameter int CHANNELS = clfd_pkg::CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pixel_index[15:0], channel_a, channel_b, channel_c
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // min_distance[33:0], winner[37:34], fg_count[53:38]
    output logic        m_tuser,   // is_background
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [33:0] thresh_reg;
    logic [16:0] coef_win_reg;
    logic [16:0] coef_all_reg;
    logic        reinit_en_reg;
    logic [15:0] reinit_lim_reg;
    logic        wr;

    clfd_pkg::ctl_t ctl;
    clfd_pkg::sts_t sts;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg     <= '0;
            coef_win_reg   <= '0;
            coef_all_reg   <= '0;
            reinit_en_reg  <= 1'b0;
            reinit_lim_reg <= '0;
        end else if (wr) begin
            unique case (paddr[5:3])
                clfd_pkg::REG_THRESH:     thresh_reg     <= pwdata[33:0];
                clfd_pkg::REG_COEF_WIN:   coef_win_reg   <= pwdata[16:0];
                clfd_pkg::REG_COEF_ALL:   coef_all_reg   <= pwdata[16:0];
                clfd_pkg::REG_REINIT_EN:  reinit_en_reg  <= pwdata[0];
                clfd_pkg::REG_REINIT_LIM: reinit_lim_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            clfd_pkg::REG_THRESH:     prdata = 64'(thresh_reg);
            clfd_pkg::REG_COEF_WIN:   prdata = 64'(coef_win_reg);
            clfd_pkg::REG_COEF_ALL:   prdata = 64'(coef_all_reg);
            clfd_pkg::REG_REINIT_EN:  prdata = 64'(reinit_en_reg);
            clfd_pkg::REG_REINIT_LIM: prdata = 64'(reinit_lim_reg);
            default:                  prdata = '0;
        endcase
    end

    clfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    clfd_dp #(.PIXELS(PIXELS), .NEURONS(NEURONS), .CHANNELS(CHANNELS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sts        (sts),
        .thresh     (thresh_reg),
        .coef_win   (coef_win_reg),
        .coef_all   (coef_all_reg),
        .reinit_en  (reinit_en_reg),
        .reinit_lim (reinit_lim_reg),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* hdl/clfd_checker.sv */
// ----------------------------------------------------------------------------
// Foreground detector checker
// Port-level properties of the input and result streams, bound to the top level.
// ----------------------------------------------------------------------------
`include "competitive_learning_foreground_detect_core_defines.svh"

module clfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    `CLFD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `CLFD_ASSERT_IMP(a_bg_count, aclk, aresetn, m_tvalid && m_tuser, m_tdata[53:38] == 16'd0, "background result with nonzero run count")
    `CLFD_ASSERT_IMP(a_fg_count, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[53:38] != 16'd0, "foreground result with zero run count")
    `CLFD_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken while one is in work")

endmodule

bind competitive_learning_foreground_detect_core clfd_checker u_clfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
